FILE: design/bis_pkg.sv
package bis_pkg;

	localparam int MAX_ROWS       = 128;
	localparam int MAX_COLS       = 128;
	localparam int STEP_FRAC_BITS = 16;

	localparam int IDX_W  = 12;
	localparam int STEP_W = 20;
	localparam int SIZE_W = 8;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int IN_W   = 2 * IDX_W + 3 * CH_W;
	localparam int LIM_W  = IDX_W + 1;

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int HALF_ROWS = (MAX_ROWS + 1) / 2;
	localparam int HALF_COLS = (MAX_COLS + 1) / 2;
	localparam int HR_W      = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
	localparam int HC_W      = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
	localparam int BANK_AW   = HR_W + HC_W;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int NUM_BANKS = 4;

	localparam int POS_W = IDX_W + STEP_W;
	localparam int W_W   = STEP_FRAC_BITS + 1;
	localparam int TOP_W = CH_W + W_W;
	localparam int ACC_W = TOP_W + W_W + 1;
	localparam int RES_W = ACC_W - 2 * STEP_FRAC_BITS;

	localparam logic [W_W-1:0]   WEIGHT_ONE = W_W'(1) << STEP_FRAC_BITS;
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (2 * STEP_FRAC_BITS - 1);
	localparam logic [CH_W-1:0]  CH_MAX     = {CH_W{1'b1}};

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [SIZE_W-1:0] SOURCE_ROWS_RST = SIZE_W'(128);
	localparam logic [SIZE_W-1:0] SOURCE_COLS_RST = SIZE_W'(128);
	localparam logic [STEP_W-1:0] ROW_STEP_RST    = STEP_W'(65536);
	localparam logic [STEP_W-1:0] COL_STEP_RST    = STEP_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_ROWS = 4'd0,
		CFG_SOURCE_COLS = 4'd1,
		CFG_ROW_STEP    = 4'd2,
		CFG_COL_STEP    = 4'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
	} in_data_t;

endpackage

FILE: design/bilinear_image_scaler.sv
// Bilinear RGB scaler with a frame store split into four banks by row and column parity.
// A query result passes five pipeline stages before it is presented on m_tdata.
// One transaction per cycle unless stalled; each bank serves one neighbor per cycle.
// Back pressure on m_tready stalls the whole pipeline; nothing is lost or repeated.
// Reset (arst_n low) clears valid bits and sets the registers to their defaults;
// the frame store has no reset and must be loaded before it is queried.
module bilinear_image_scaler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bis_pkg::IN_W-1:0]         s_tdata,   // row, col, red_in, green_in, blue_in
	input  logic [0:0]                       s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bis_pkg::PIX_W-1:0]        m_tdata,   // red_out, green_out, blue_out
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [bis_pkg::SIZE_W-1:0] source_rows_q, source_cols_q;
	logic [bis_pkg::STEP_W-1:0] row_step_q, col_step_q;

	logic [bis_pkg::LIM_W-1:0] rows_eff, cols_eff;
	logic [bis_pkg::ROW_W-1:0] row_last;
	logic [bis_pkg::COL_W-1:0] col_last;

	logic adv, accept;
	bis_pkg::in_data_t in_d;

	// stage 1
	logic                        valid_s1;
	bis_pkg::kind_t              kind_s1;
	logic [bis_pkg::IDX_W-1:0]   row_s1, col_s1;
	logic [bis_pkg::PIX_W-1:0]   pix_s1;
	logic [bis_pkg::POS_W-1:0]   pos_r_s1, pos_c_s1;

	// stage 2
	logic                                 valid_s2;
	bis_pkg::kind_t                       kind_s2;
	logic                                 wr_ok_s2;
	logic [bis_pkg::PIX_W-1:0]            pix_s2;
	logic [bis_pkg::ROW_W-1:0]            r1_s2, r2_s2;
	logic [bis_pkg::COL_W-1:0]            c1_s2, c2_s2;
	logic [bis_pkg::STEP_FRAC_BITS-1:0]   fr_s2, fc_s2;
	logic                                 we_s2;

	logic [bis_pkg::POS_W-1:0]          ip_r, ip_c;
	logic                               clamp_r, clamp_c;
	logic [bis_pkg::ROW_W-1:0]          r1_d, r2_d;
	logic [bis_pkg::COL_W-1:0]          c1_d, c2_d;
	logic                               wr_ok_d;

	// stage 3
	logic                                 valid_s3;
	logic [bis_pkg::PIX_W-1:0]            bank_rd_s3 [bis_pkg::NUM_BANKS];
	logic                                 r1p_s3, r2p_s3, c1p_s3, c2p_s3;
	logic [bis_pkg::STEP_FRAC_BITS-1:0]   fr_s3, fc_s3;

	// stage 4
	logic                                 valid_s4;
	logic [bis_pkg::TOP_W-1:0]            top_s4 [3];
	logic [bis_pkg::TOP_W-1:0]            bot_s4 [3];
	logic [bis_pkg::STEP_FRAC_BITS-1:0]   fr_s4;
	logic [bis_pkg::TOP_W-1:0]            top_d [3];
	logic [bis_pkg::TOP_W-1:0]            bot_d [3];
	logic [bis_pkg::PIX_W-1:0]            p11, p12, p21, p22;
	logic [bis_pkg::W_W-1:0]              wc_lo, wc_hi;

	// stage 5
	logic                        valid_s5;
	logic [bis_pkg::PIX_W-1:0]   out_s5;
	logic [bis_pkg::PIX_W-1:0]   out_d;
	logic [bis_pkg::W_W-1:0]     wr_lo, wr_hi;
	logic [bis_pkg::ACC_W-1:0]   acc [3];
	logic [bis_pkg::RES_W-1:0]   res [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rows_q <= bis_pkg::SOURCE_ROWS_RST;
			source_cols_q <= bis_pkg::SOURCE_COLS_RST;
			row_step_q    <= bis_pkg::ROW_STEP_RST;
			col_step_q    <= bis_pkg::COL_STEP_RST;
		end else if (cfg_valid) begin
			unique case (bis_pkg::cfg_reg_t'(cfg_index))
				bis_pkg::CFG_SOURCE_ROWS: source_rows_q <= cfg_data[bis_pkg::SIZE_W-1:0];
				bis_pkg::CFG_SOURCE_COLS: source_cols_q <= cfg_data[bis_pkg::SIZE_W-1:0];
				bis_pkg::CFG_ROW_STEP:    row_step_q    <= cfg_data[bis_pkg::STEP_W-1:0];
				bis_pkg::CFG_COL_STEP:    col_step_q    <= cfg_data[bis_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (source_rows_q == '0) begin
			rows_eff = bis_pkg::LIM_W'(1);
		end else if (bis_pkg::LIM_W'(source_rows_q) > bis_pkg::LIM_W'(bis_pkg::MAX_ROWS)) begin
			rows_eff = bis_pkg::LIM_W'(bis_pkg::MAX_ROWS);
		end else begin
			rows_eff = bis_pkg::LIM_W'(source_rows_q);
		end
		if (source_cols_q == '0) begin
			cols_eff = bis_pkg::LIM_W'(1);
		end else if (bis_pkg::LIM_W'(source_cols_q) > bis_pkg::LIM_W'(bis_pkg::MAX_COLS)) begin
			cols_eff = bis_pkg::LIM_W'(bis_pkg::MAX_COLS);
		end else begin
			cols_eff = bis_pkg::LIM_W'(source_cols_q);
		end
		row_last = bis_pkg::ROW_W'(rows_eff - bis_pkg::LIM_W'(1));
		col_last = bis_pkg::COL_W'(cols_eff - bis_pkg::LIM_W'(1));
	end

	assign adv      = !valid_s5 || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign in_d     = bis_pkg::in_data_t'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && (kind_s2 == bis_pkg::KIND_QUERY);
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: map coordinates into the source
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= bis_pkg::kind_t'(s_tuser[0]);
			row_s1   <= in_d.row;
			col_s1   <= in_d.col;
			pix_s1   <= {in_d.blue, in_d.green, in_d.red};
			pos_r_s1 <= bis_pkg::POS_W'(in_d.row) * bis_pkg::POS_W'(row_step_q);
			pos_c_s1 <= bis_pkg::POS_W'(in_d.col) * bis_pkg::POS_W'(col_step_q);
		end
	end

	// stage 2: neighbor indices with edge clamp; loads reuse r1/c1 as write address
	always_comb begin
		ip_r    = pos_r_s1 >> bis_pkg::STEP_FRAC_BITS;
		ip_c    = pos_c_s1 >> bis_pkg::STEP_FRAC_BITS;
		clamp_r = ip_r >= bis_pkg::POS_W'(row_last);
		clamp_c = ip_c >= bis_pkg::POS_W'(col_last);
		wr_ok_d = (bis_pkg::LIM_W'(row_s1) < bis_pkg::LIM_W'(bis_pkg::MAX_ROWS)) &&
		          (bis_pkg::LIM_W'(col_s1) < bis_pkg::LIM_W'(bis_pkg::MAX_COLS));
		if (kind_s1 == bis_pkg::KIND_LOAD) begin
			r1_d = row_s1[bis_pkg::ROW_W-1:0];
			r2_d = row_s1[bis_pkg::ROW_W-1:0];
			c1_d = col_s1[bis_pkg::COL_W-1:0];
			c2_d = col_s1[bis_pkg::COL_W-1:0];
		end else begin
			r1_d = clamp_r ? row_last : ip_r[bis_pkg::ROW_W-1:0];
			r2_d = clamp_r ? row_last : r1_d + bis_pkg::ROW_W'(1);
			c1_d = clamp_c ? col_last : ip_c[bis_pkg::COL_W-1:0];
			c2_d = clamp_c ? col_last : c1_d + bis_pkg::COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2  <= kind_s1;
			wr_ok_s2 <= wr_ok_d;
			pix_s2   <= pix_s1;
			r1_s2    <= r1_d;
			r2_s2    <= r2_d;
			c1_s2    <= c1_d;
			c2_s2    <= c2_d;
			fr_s2    <= pos_r_s1[bis_pkg::STEP_FRAC_BITS-1:0];
			fc_s2    <= pos_c_s1[bis_pkg::STEP_FRAC_BITS-1:0];
		end
	end

	assign we_s2 = valid_s2 && (kind_s2 == bis_pkg::KIND_LOAD) && wr_ok_s2;

	// stage 3: banked frame store, bank index is {row parity, col parity}
	for (genvar b = 0; b < bis_pkg::NUM_BANKS; b++) begin : g_bank
		localparam logic RP = 1'(b / 2);
		localparam logic CP = 1'(b % 2);
		logic [bis_pkg::PIX_W-1:0]   store_q [bis_pkg::BANK_DEPTH];
		logic [bis_pkg::ROW_W-1:0]   row_sel;
		logic [bis_pkg::COL_W-1:0]   col_sel;
		logic [bis_pkg::BANK_AW-1:0] addr;
		logic [bis_pkg::ROW_W-1:0]   row_half;
		logic [bis_pkg::COL_W-1:0]   col_half;

		always_comb begin
			row_sel  = (r1_s2[0] == RP) ? r1_s2 : r2_s2;
			col_sel  = (c1_s2[0] == CP) ? c1_s2 : c2_s2;
			row_half = row_sel >> 1;
			col_half = col_sel >> 1;
			addr     = {bis_pkg::HR_W'(row_half), bis_pkg::HC_W'(col_half)};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (we_s2 && (r1_s2[0] == RP) && (c1_s2[0] == CP)) begin
					store_q[addr] <= pix_s2;
				end
				bank_rd_s3[b] <= store_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r1p_s3 <= r1_s2[0];
			r2p_s3 <= r2_s2[0];
			c1p_s3 <= c1_s2[0];
			c2p_s3 <= c2_s2[0];
			fr_s3  <= fr_s2;
			fc_s3  <= fc_s2;
		end
	end

	// stage 4: horizontal blend of both rows
	always_comb begin
		p11   = bank_rd_s3[{r1p_s3, c1p_s3}];
		p12   = bank_rd_s3[{r1p_s3, c2p_s3}];
		p21   = bank_rd_s3[{r2p_s3, c1p_s3}];
		p22   = bank_rd_s3[{r2p_s3, c2p_s3}];
		wc_hi = bis_pkg::W_W'(fc_s3);
		wc_lo = bis_pkg::WEIGHT_ONE - wc_hi;
		for (int ch = 0; ch < 3; ch++) begin
			top_d[ch] = bis_pkg::TOP_W'(p11[ch*bis_pkg::CH_W +: bis_pkg::CH_W]) *
			            bis_pkg::TOP_W'(wc_lo) +
			            bis_pkg::TOP_W'(p12[ch*bis_pkg::CH_W +: bis_pkg::CH_W]) *
			            bis_pkg::TOP_W'(wc_hi);
			bot_d[ch] = bis_pkg::TOP_W'(p21[ch*bis_pkg::CH_W +: bis_pkg::CH_W]) *
			            bis_pkg::TOP_W'(wc_lo) +
			            bis_pkg::TOP_W'(p22[ch*bis_pkg::CH_W +: bis_pkg::CH_W]) *
			            bis_pkg::TOP_W'(wc_hi);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_s4 <= top_d;
			bot_s4 <= bot_d;
			fr_s4  <= fr_s3;
		end
	end

	// stage 5: vertical blend, round half up, saturate
	always_comb begin
		wr_hi = bis_pkg::W_W'(fr_s4);
		wr_lo = bis_pkg::WEIGHT_ONE - wr_hi;
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = bis_pkg::ACC_W'(top_s4[ch]) * bis_pkg::ACC_W'(wr_lo) +
			          bis_pkg::ACC_W'(bot_s4[ch]) * bis_pkg::ACC_W'(wr_hi) +
			          bis_pkg::ROUND_HALF;
			res[ch] = bis_pkg::RES_W'(acc[ch] >> (2 * bis_pkg::STEP_FRAC_BITS));
			out_d[ch*bis_pkg::CH_W +: bis_pkg::CH_W] =
				(res[ch] > bis_pkg::RES_W'(bis_pkg::CH_MAX)) ? bis_pkg::CH_MAX
				                                            : res[ch][bis_pkg::CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s5 <= out_d;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = out_s5;

	a_row_nbr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (kind_s2 == bis_pkg::KIND_QUERY) |->
		(r2_s2 == r1_s2 || r2_s2 == r1_s2 + bis_pkg::ROW_W'(1)) && (r2_s2 <= row_last))
		else $error("row neighbors out of order or past the last row");

	a_col_nbr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (kind_s2 == bis_pkg::KIND_QUERY) |->
		(c2_s2 == c1_s2 || c2_s2 == c1_s2 + bis_pkg::COL_W'(1)) && (c2_s2 <= col_last))
		else $error("column neighbors out of order or past the last column");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && $past(adv) |-> $past(valid_s2 && (kind_s2 == bis_pkg::KIND_QUERY)))
		else $error("load transaction entered the result path");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s4))
		else $error("result appeared without a preceding stage");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bis_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 4'd15;
	localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int TARGET_ITEMS = 1150;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic [0:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [PIX_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bilinear_image_scaler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of block state
	rgb_t              pixel_mem [STORE_DEPTH];
	bit                pixel_loaded [STORE_DEPTH];
	logic [SIZE_W-1:0] src_rows_q = SOURCE_ROWS_RST;
	logic [SIZE_W-1:0] src_cols_q = SOURCE_COLS_RST;
	logic [STEP_W-1:0] row_step_q = ROW_STEP_RST;
	logic [STEP_W-1:0] col_step_q = COL_STEP_RST;

	rgb_t pending_pixels [$];
	int   error_count   = 0;
	int   items_sent    = 0;
	bit   send_gaps_on  = 1'b1;
	bit   recv_stalls_on = 1'b1;
	int   recv_hold     = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int eff_dim(logic [SIZE_W-1:0] reg_v, int maxv);
		if (reg_v == 0)
			return 1;
		if (int'(reg_v) > maxv)
			return maxv;
		return int'(reg_v);
	endfunction

	function automatic void map_axis(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] step,
		input int size, output int lo, output int hi, output logic [63:0] frac);
		logic [63:0] pos;
		logic [63:0] ip;
		pos  = 64'(idx) * 64'(step);
		ip   = pos >> STEP_FRAC_BITS;
		frac = pos & ((64'd1 << STEP_FRAC_BITS) - 64'd1);
		if (ip >= 64'(size - 1)) begin
			lo = size - 1;
			hi = size - 1;
		end else begin
			lo = int'(ip);
			hi = int'(ip) + 1;
		end
	endfunction

	function automatic logic [CH_W-1:0] blend(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
		logic [CH_W-1:0] c, logic [CH_W-1:0] d, logic [63:0] wa, logic [63:0] wb,
		logic [63:0] wc, logic [63:0] wd);
		logic [63:0] acc;
		logic [63:0] v;
		acc = 64'(a) * wa + 64'(b) * wb + 64'(c) * wc + 64'(d) * wd;
		v   = (acc + (64'd1 << (2 * STEP_FRAC_BITS - 1))) >> (2 * STEP_FRAC_BITS);
		if (v > 64'd255)
			v = 64'd255;
		return v[CH_W-1:0];
	endfunction

	function automatic rgb_t interpolate_pixel(logic [IDX_W-1:0] qrow, logic [IDX_W-1:0] qcol);
		int          r1, r2, c1, c2;
		logic [63:0] fr, fc, one, w11, w12, w21, w22;
		rgb_t        p11, p12, p21, p22, res;
		map_axis(qrow, row_step_q, eff_dim(src_rows_q, MAX_ROWS), r1, r2, fr);
		map_axis(qcol, col_step_q, eff_dim(src_cols_q, MAX_COLS), c1, c2, fc);
		one = 64'd1 << STEP_FRAC_BITS;
		w11 = (one - fr) * (one - fc);
		w12 = (one - fr) * fc;
		w21 = fr * (one - fc);
		w22 = fr * fc;
		p11 = pixel_mem[r1 * MAX_COLS + c1];
		p12 = pixel_mem[r1 * MAX_COLS + c2];
		p21 = pixel_mem[r2 * MAX_COLS + c1];
		p22 = pixel_mem[r2 * MAX_COLS + c2];
		res.red   = blend(p11.red, p12.red, p21.red, p22.red, w11, w12, w21, w22);
		res.green = blend(p11.green, p12.green, p21.green, p22.green, w11, w12, w21, w22);
		res.blue  = blend(p11.blue, p12.blue, p21.blue, p22.blue, w11, w12, w21, w22);
		return res;
	endfunction

	// one input transaction; keeps tvalid high when the next one follows without a gap
	task automatic send_item(kind_t kind, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
		logic [CH_W-1:0] red, logic [CH_W-1:0] green, logic [CH_W-1:0] blue);
		int       gap;
		in_data_t d;
		gap = send_gaps_on ? $urandom_range(15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		d.row   = row;
		d.col   = col;
		d.red   = red;
		d.green = green;
		d.blue  = blue;
		s_tdata  <= d;
		s_tuser  <= kind;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == KIND_LOAD) begin
			if (row < MAX_ROWS && col < MAX_COLS) begin
				pixel_mem[int'(row) * MAX_COLS + int'(col)]    = {blue, green, red};
				pixel_loaded[int'(row) * MAX_COLS + int'(col)] = 1'b1;
				items_sent++;
			end
		end else begin
			pending_pixels.push_back(interpolate_pixel(row, col));
			items_sent++;
		end
	endtask

	task automatic send_load(int row, int col);
		send_item(KIND_LOAD, row[IDX_W-1:0], col[IDX_W-1:0], CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)), CH_W'($urandom_range(255)));
	endtask

	task automatic send_query(int row, int col);
		send_item(KIND_QUERY, row[IDX_W-1:0], col[IDX_W-1:0], CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)), CH_W'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SOURCE_ROWS: src_rows_q = data[SIZE_W-1:0];
			CFG_SOURCE_COLS: src_cols_q = data[SIZE_W-1:0];
			CFG_ROW_STEP:    row_step_q = data[STEP_W-1:0];
			CFG_COL_STEP:    col_step_q = data[STEP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_scale(int rows, int cols, int rstep, int cstep);
		wait_idle();
		cfg_write(CFG_SOURCE_ROWS, CFG_DATA_W'(rows));
		cfg_write(CFG_SOURCE_COLS, CFG_DATA_W'(cols));
		cfg_write(CFG_ROW_STEP, CFG_DATA_W'(rstep));
		cfg_write(CFG_COL_STEP, CFG_DATA_W'(cstep));
	endtask

	// fill the part of the store that queries can reach
	task automatic load_region(bit only_new);
		int er, ec;
		er = eff_dim(src_rows_q, MAX_ROWS);
		ec = eff_dim(src_cols_q, MAX_COLS);
		for (int r = 0; r < er; r++)
			for (int c = 0; c < ec; c++)
				if (!only_new || !pixel_loaded[r * MAX_COLS + c])
					send_load(r, c);
	endtask

	task automatic test_reset_defaults();
		send_item(KIND_LOAD, 12'd126, 12'd126, 8'd0, 8'd255, 8'd0);
		send_item(KIND_LOAD, 12'd126, 12'd127, 8'd255, 8'd0, 8'd255);
		send_item(KIND_LOAD, 12'd127, 12'd126, 8'd255, 8'd255, 8'd255);
		send_item(KIND_LOAD, 12'd127, 12'd127, 8'd0, 8'd0, 8'd0);
		send_query(126, 126);
		send_query(127, 127);
		send_item(KIND_QUERY, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
	endtask

	task automatic test_load_out_of_range();
		send_item(KIND_LOAD, 12'd254, 12'd254, 8'hAA, 8'h55, 8'hAA);
		send_item(KIND_LOAD, 12'd126, 12'd4094, 8'h55, 8'hAA, 8'h55);
		send_item(KIND_LOAD, 12'd4095, 12'd127, 8'hFF, 8'hFF, 8'hFF);
		send_query(126, 126);
	endtask

	task automatic test_fractional_steps();
		set_scale(2, 2, 32768, 98304);
		send_item(KIND_LOAD, 12'd0, 12'd0, 8'd255, 8'd0, 8'd1);
		send_item(KIND_LOAD, 12'd0, 12'd1, 8'd0, 8'd255, 8'd2);
		send_item(KIND_LOAD, 12'd1, 12'd0, 8'd1, 8'd128, 8'd255);
		send_item(KIND_LOAD, 12'd1, 12'd1, 8'd255, 8'd255, 8'd0);
		wait_idle();
		cfg_write(CFG_UNUSED_LOW, 20'hFFFFF);
		cfg_write(CFG_UNUSED_HIGH, 20'h00001);
		send_query(1, 1);
		send_query(0, 1);
		send_query(1, 0);
	endtask

	task automatic test_zero_step_and_sizes();
		set_scale(0, 255, 0, 0);
		send_query(0, 0);
		send_query(4095, 4095);
		wait_idle();
		cfg_write(CFG_ROW_STEP, 20'hFFFFF);
		cfg_write(CFG_SOURCE_COLS, 20'hABC01);
		send_query(1234, 77);
	endtask

	task automatic test_backpressure();
		set_scale(4, 4, 40000, 24000);
		load_region(1'b0);
		wait_idle();
		send_gaps_on = 1'b0;
		recv_hold    = 300;
		repeat (48) send_query($urandom_range(9), $urandom_range(9));
		wait_idle();
		send_gaps_on = 1'b1;
	endtask

	function automatic int pick_step();
		case ($urandom_range(5))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(131071, 1);
			3: return $urandom_range(20'hFFFFF);
			4: return 20'hFFFFF;
			default: return $urandom_range(65536, 16384);
		endcase
	endfunction

	function automatic int pick_dim(bit allow_large);
		int sel;
		sel = $urandom_range(19);
		if (sel == 0)
			return 0;
		if (sel == 1 && allow_large)
			return $urandom_range(255, 128);
		return $urandom_range(8, 1);
	endfunction

	task automatic test_random_scaling();
		int phase, rows, cols, er, ec, nq, sel;
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			if (phase == 0) begin
				rows = 128;
				cols = 1;
			end else if (phase == 1) begin
				rows = 0;
				cols = 255;
			end else begin
				rows = pick_dim(1'b1);
				cols = (eff_dim(SIZE_W'(rows), MAX_ROWS) > 8) ? $urandom_range(1)
				                                              : pick_dim(1'b1);
				if (eff_dim(SIZE_W'(cols), MAX_COLS) > 8 &&
				    eff_dim(SIZE_W'(rows), MAX_ROWS) > 1)
					rows = 1;
			end
			set_scale(rows, cols, pick_step(), pick_step());
			if ($urandom_range(3) == 0)
				cfg_write(CFG_UNUSED_HIGH - CFG_IDX_W'($urandom_range(9)),
					CFG_DATA_W'($urandom_range(20'hFFFFF)));
			send_gaps_on   = ($urandom_range(3) != 0);
			recv_stalls_on = ($urandom_range(3) != 0);
			er = eff_dim(src_rows_q, MAX_ROWS);
			ec = eff_dim(src_cols_q, MAX_COLS);
			load_region(er * ec > 64);
			nq = $urandom_range(40, 20);
			repeat (nq) begin
				sel = $urandom_range(99);
				if (sel < 64)
					send_query($urandom_range(63), $urandom_range(63));
				else if (sel < 80)
					send_query($urandom_range(4095), $urandom_range(4095));
				else if (sel < 92)
					send_load($urandom_range(er - 1), $urandom_range(ec - 1));
				else if (sel < 96)
					send_load($urandom_range(4095, MAX_ROWS), $urandom_range(4095));
				else
					send_load($urandom_range(MAX_ROWS - 1), $urandom_range(4095, MAX_COLS));
			end
			phase++;
		end
		wait_idle();
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
	endtask

	// result side: random stalls, long hold-off on request
	initial begin : result_checker
		int   stall;
		rgb_t got;
		rgb_t want;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (recv_hold > 0) begin
				m_tready <= 1'b0;
				repeat (recv_hold) @(posedge clk);
				recv_hold = 0;
			end
			stall = recv_stalls_on ? $urandom_range(15) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid && recv_hold == 0) @(posedge clk);
			if (m_tvalid) begin
				got = m_tdata;
				if (pending_pixels.size() == 0) begin
					$error("unexpected result transaction: %h", got);
					error_count++;
				end else begin
					want = pending_pixels.pop_front();
					if (got.red !== want.red) begin
						$error("red_out: expected %0d, actual %0d", want.red, got.red);
						error_count++;
					end
					if (got.green !== want.green) begin
						$error("green_out: expected %0d, actual %0d", want.green, got.green);
						error_count++;
					end
					if (got.blue !== want.blue) begin
						$error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_load_out_of_range();
		test_fractional_steps();
		test_zero_step_and_sizes();
		test_backpressure();
		test_random_scaling();
		wait_idle();
		if (error_count == 0 && pending_pixels.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
